// ===== rtl/drc_pkg.sv =====
`timescale 1ns / 1ps
package drc_pkg;

	localparam int FRAC_BITS = 16;
	localparam longint ONE = 64'd1 << FRAC_BITS;

	// field widths of the channels
	localparam int SW_W   = 13;
	localparam int POS_W  = 22;
	localparam int VEC_W  = 19;
	localparam int COL_W  = 12;
	localparam int CELL_W = 6;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int DIST_W = 32;
	localparam int LINE_W = 13;
	localparam int CIDX_W = 4;
	localparam int CDAT_W = 32;

	// shared divider
	localparam int NUM_W = 45;
	localparam int DEN_W = 33;

	localparam logic [DIST_W-1:0] DIST_CAP = '1;
	localparam int LH_W = 21;
	localparam logic [LH_W-1:0] LINE_CAP = LH_W'(1) << 20;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DOOR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

	localparam logic [STAT_W-1:0] ST_HIT   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_WRITE = 2'd2;

	localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
	localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
	localparam logic [CIDX_W-1:0] REG_PLAYER_X      = 4'd2;
	localparam logic [CIDX_W-1:0] REG_PLAYER_Y      = 4'd3;
	localparam logic [CIDX_W-1:0] REG_VIEW_DIR_X    = 4'd4;
	localparam logic [CIDX_W-1:0] REG_VIEW_DIR_Y    = 4'd5;
	localparam logic [CIDX_W-1:0] REG_CAM_PLANE_X   = 4'd6;
	localparam logic [CIDX_W-1:0] REG_CAM_PLANE_Y   = 4'd7;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/drc_ifs.sv =====
`timescale 1ns / 1ps
interface drc_cmd_if;
	import drc_pkg::*;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [COL_W-1:0]  column;
	logic [CELL_W-1:0] cell_row;
	logic [CELL_W-1:0] cell_col;
	logic [KIND_W-1:0] cell_kind;
	modport source (output valid, opcode, column, cell_row, cell_col, cell_kind, input ready);
	modport sink (input valid, opcode, column, cell_row, cell_col, cell_kind, output ready);
endinterface

interface drc_res_if;
	import drc_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              hit_side;
	logic [CELL_W-1:0] hit_row;
	logic [CELL_W-1:0] hit_col;
	logic [KIND_W-1:0] hit_kind;
	logic [DIST_W-1:0] wall_distance;
	logic [LINE_W-1:0] line_top;
	logic [LINE_W-1:0] line_bottom;
	modport source (output valid, status, hit_side, hit_row, hit_col, hit_kind,
		wall_distance, line_top, line_bottom, input ready);
	modport sink (input valid, status, hit_side, hit_row, hit_col, hit_kind,
		wall_distance, line_top, line_bottom, output ready);
endinterface

interface drc_cfg_if;
	import drc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/drc_ram.sv =====
`timescale 1ns / 1ps
module drc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/drc_div.sv =====
`timescale 1ns / 1ps
module drc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [drc_pkg::NUM_W-1:0] num,
	input  logic [drc_pkg::DEN_W-1:0] den,
	output logic [drc_pkg::NUM_W-1:0] quo,
	output drc_pkg::div_stat_t        stat
);
	import drc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/dda_raycast_wall_column_unit.sv =====
`timescale 1ns / 1ps
// channel  modport  handshake        carries
// cmd      sink     valid / ready    opcode, column, cell_row, cell_col, cell_kind
// res      source   valid / ready    status, hit side, hit cell, kind, distance, slice rows
// cfg      sink     valid / ready    register index, write data (ready always high)
//
// a write item passes S_WR and S_FIN; a cast uses the divider for camera x, the
// multiplier for the ray, the divider for the two step distances, the multiplier for
// the side distances, dda steps (step, map read, check) up to MAP_ROWS + MAP_COLS steps,
// and the divider for the slice height, paced by the one shared radix-2 divider and the single map read port
// after reset the map is cleared one cell a cycle with cmd.ready low; configuration
// writes are taken meanwhile
// cmd.ready is high whenever the sequencer is idle and the map is not being cleared, even while a result waits on res
module dda_raycast_wall_column_unit #(
	parameter int MAP_ROWS = 64,
	parameter int MAP_COLS = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	drc_cmd_if.sink   cmd,
	drc_res_if.source res,
	drc_cfg_if.sink   cfg
);
	import drc_pkg::*;

	localparam int DEPTH      = MAP_ROWS * MAP_COLS;
	localparam int AW         = $clog2(DEPTH);
	localparam int RB         = $clog2(MAP_ROWS + 1);
	localparam int CB         = $clog2(MAP_COLS + 1);
	localparam int MX_W       = ((RB > CELL_W) ? RB : CELL_W) + 2;
	localparam int MY_W       = ((CB > CELL_W) ? CB : CELL_W) + 2;
	localparam int STEP_LIMIT = MAP_ROWS + MAP_COLS;
	localparam int SC_W       = $clog2(STEP_LIMIT + 1);
	localparam int CAM_W      = 30;
	localparam int RAY_W      = 34;
	localparam int MA_W       = 20;
	localparam int MB_W       = 34;
	localparam int PROD_W     = MA_W + MB_W;

	typedef enum logic [3:0] {
		S_IDLE, S_WR, S_CAM, S_MULX, S_RAYX, S_RAYY, S_DX, S_DY,
		S_SX, S_SXW, S_SYW, S_STEP, S_RD, S_CHK, S_LH, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [SW_W-1:0]         sw_q, sh_q;
	logic [POS_W-1:0]        px_q, py_q;
	logic signed [VEC_W-1:0] dirx_q, diry_q, plx_q, ply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= 13'd640;
			sh_q   <= 13'd480;
			px_q   <= 22'd98304;
			py_q   <= 22'd98304;
			dirx_q <= -19'sd65536;
			diry_q <= '0;
			plx_q  <= '0;
			ply_q  <= 19'sd43254;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SCREEN_WIDTH:  sw_q   <= cfg.data[SW_W-1:0];
				REG_SCREEN_HEIGHT: sh_q   <= cfg.data[SW_W-1:0];
				REG_PLAYER_X:      px_q   <= cfg.data[POS_W-1:0];
				REG_PLAYER_Y:      py_q   <= cfg.data[POS_W-1:0];
				REG_VIEW_DIR_X:    dirx_q <= $signed(cfg.data[VEC_W-1:0]);
				REG_VIEW_DIR_Y:    diry_q <= $signed(cfg.data[VEC_W-1:0]);
				REG_CAM_PLANE_X:   plx_q  <= $signed(cfg.data[VEC_W-1:0]);
				REG_CAM_PLANE_Y:   ply_q  <= $signed(cfg.data[VEC_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// map clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// latched item
	logic              op_q;
	logic [COL_W-1:0]  col_q;
	logic [CELL_W-1:0] wrow_q, wcol_q;
	logic [KIND_W-1:0] wkind_q;

	wire cmd_acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE) && !clr_busy_q;

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd.opcode;
			col_q   <= cmd.column;
			wrow_q  <= cmd.cell_row;
			wcol_q  <= cmd.cell_col;
			wkind_q <= cmd.cell_kind;
		end
	end

	// datapath registers
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [RAY_W-1:0]  rx_q, ry_q;
	logic [DIST_W-1:0]        dx_q, dy_q, sx_q, sy_q, dist_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MX_W-1:0]   mx_q;
	logic signed [MY_W-1:0]   my_q;
	logic [SC_W-1:0]          step_cnt_q;
	logic                     side_q;
	logic [KIND_W-1:0]        kind_q;
	logic [LH_W-1:0]          lh_q;
	logic [STAT_W-1:0]        stat_q;

	// shared multiplier
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [FRAC_BITS:0]     fx, fy, fx_inv, fy_inv;

	assign fx     = {1'b0, px_q[FRAC_BITS-1:0]};
	assign fy     = {1'b0, py_q[FRAC_BITS-1:0]};
	assign fx_inv = (FRAC_BITS+1)'(ONE) - fx;
	assign fy_inv = (FRAC_BITS+1)'(ONE) - fy;

	wire rx_neg = rx_q[RAY_W-1];
	wire ry_neg = ry_q[RAY_W-1];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = MA_W'(plx_q);
				mul_b = MB_W'(cam_q);
			end
			S_RAYX: begin
				mul_a = MA_W'(ply_q);
				mul_b = MB_W'(cam_q);
			end
			S_SX: begin
				mul_a = $signed(MA_W'(rx_neg ? fx : fx_inv));
				mul_b = $signed(MB_W'(dx_q));
			end
			S_SXW: begin
				mul_a = $signed(MA_W'(ry_neg ? fy : fy_inv));
				mul_b = $signed(MB_W'(dy_q));
			end
			default: ;
		endcase
	end

	logic [PROD_W-FRAC_BITS-1:0] side_raw;
	logic [DIST_W-1:0]           side_sat;

	assign side_raw = prod_q[PROD_W-1:FRAC_BITS];
	assign side_sat = (|side_raw[PROD_W-FRAC_BITS-1:DIST_W]) ? DIST_CAP
		: side_raw[DIST_W-1:0];

	// shared divider
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den;
	logic             div_start, div_run_q;
	div_stat_t        div_st;
	logic [RAY_W-1:0] rx_abs, ry_abs;
	logic [SW_W-1:0]  w_eff;

	assign rx_abs = rx_neg ? RAY_W'(-rx_q) : RAY_W'(rx_q);
	assign ry_abs = ry_neg ? RAY_W'(-ry_q) : RAY_W'(ry_q);
	assign w_eff  = (sw_q == '0) ? SW_W'(1) : sw_q;

	wire rx_zero   = (rx_q == '0);
	wire ry_zero   = (ry_q == '0);
	wire dist_zero = (dist_q == '0);

	always_comb begin
		div_num   = '0;
		div_den   = '0;
		div_start = 1'b0;
		case (state_q)
			S_CAM: begin
				div_num   = NUM_W'(col_q) << (FRAC_BITS + 1);
				div_den   = DEN_W'(w_eff);
				div_start = !div_run_q;
			end
			S_DX: begin
				div_num   = NUM_W'(1) << (2 * FRAC_BITS);
				div_den   = rx_abs[DEN_W-1:0];
				div_start = !div_run_q && !rx_zero;
			end
			S_DY: begin
				div_num   = NUM_W'(1) << (2 * FRAC_BITS);
				div_den   = ry_abs[DEN_W-1:0];
				div_start = !div_run_q && !ry_zero;
			end
			S_LH: begin
				div_num   = NUM_W'(sh_q) << (2 * FRAC_BITS);
				div_den   = DEN_W'(dist_q);
				div_start = !div_run_q && !dist_zero;
			end
			default: ;
		endcase
	end

	drc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_st)
	);

	wire [DIST_W-1:0] recip = (|div_quo[NUM_W-1:DIST_W]) ? DIST_CAP : div_quo[DIST_W-1:0];

	// map
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [KIND_W-1:0] ram_wdata, ram_rdata;

	wire wr_in_map = (32'(wrow_q) < MAP_ROWS) && (32'(wcol_q) < MAP_COLS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(wrow_q) * AW'(MAP_COLS) + AW'(wcol_q);
		ram_wdata = (wkind_q == KIND_RSVD) ? KIND_EMPTY : wkind_q;
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = KIND_EMPTY;
		end else if (state_q == S_WR) begin
			ram_we = wr_in_map;
		end
	end

	assign ram_raddr = AW'(mx_q) * AW'(MAP_COLS) + AW'(my_q);

	drc_ram #(
		.WIDTH (KIND_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wire out_of_map = mx_q[MX_W-1] || my_q[MY_W-1]
		|| (mx_q >= $signed(MX_W'(MAP_ROWS))) || (my_q >= $signed(MY_W'(MAP_COLS)));
	wire cell_hit   = (ram_rdata == KIND_WALL) || (ram_rdata == KIND_DOOR);
	wire limit_hit  = (step_cnt_q == SC_W'(STEP_LIMIT));
	wire x_first    = sx_q < sy_q;

	wire [DIST_W:0] sx_sum = {1'b0, sx_q} + {1'b0, dx_q};
	wire [DIST_W:0] sy_sum = {1'b0, sy_q} + {1'b0, dy_q};

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_CAM: if (div_st.done) begin
				cam_q <= $signed(CAM_W'(div_quo) - CAM_W'(ONE));
			end
			S_RAYX: rx_q <= RAY_W'(dirx_q) + RAY_W'(prod_q >>> FRAC_BITS);
			S_RAYY: ry_q <= RAY_W'(diry_q) + RAY_W'(prod_q >>> FRAC_BITS);
			S_DX: begin
				if (rx_zero) begin
					dx_q <= DIST_CAP;
				end else if (div_st.done) begin
					dx_q <= recip;
				end
			end
			S_DY: begin
				if (ry_zero) begin
					dy_q <= DIST_CAP;
				end else if (div_st.done) begin
					dy_q <= recip;
				end
			end
			S_SXW: sx_q <= side_sat;
			S_SYW: begin
				sy_q       <= side_sat;
				mx_q       <= $signed(MX_W'(px_q[POS_W-1:FRAC_BITS]));
				my_q       <= $signed(MY_W'(py_q[POS_W-1:FRAC_BITS]));
				step_cnt_q <= '0;
			end
			S_STEP: begin
				step_cnt_q <= step_cnt_q + SC_W'(1);
				if (x_first) begin
					sx_q   <= sx_sum[DIST_W] ? DIST_CAP : sx_sum[DIST_W-1:0];
					mx_q   <= rx_neg ? mx_q - MX_W'(1) : mx_q + MX_W'(1);
					side_q <= 1'b0;
				end else begin
					sy_q   <= sy_sum[DIST_W] ? DIST_CAP : sy_sum[DIST_W-1:0];
					my_q   <= ry_neg ? my_q - MY_W'(1) : my_q + MY_W'(1);
					side_q <= 1'b1;
				end
			end
			S_CHK: begin
				kind_q <= ram_rdata;
				dist_q <= side_q ? sy_q - dy_q : sx_q - dx_q;
			end
			S_LH: begin
				if (dist_zero) begin
					lh_q <= LINE_CAP;
				end else if (div_st.done) begin
					lh_q <= (div_quo > NUM_W'(LINE_CAP)) ? LINE_CAP : div_quo[LH_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// slice rows from the clamped height
	logic [SW_W-2:0]   hh;
	logic [LH_W-2:0]   half;
	logic [LH_W-1:0]   bot_sum;
	logic [LINE_W-1:0] top_v, bot_v;

	assign hh      = sh_q[SW_W-1:1];
	assign half    = lh_q[LH_W-1:1];
	assign bot_sum = LH_W'(hh) + LH_W'(half);
	assign top_v   = (half >= (LH_W-1)'(hh)) ? '0 : LINE_W'(hh - half[SW_W-2:0]);
	assign bot_v   = (bot_sum > LH_W'(sh_q)) ? sh_q : bot_sum[LINE_W-1:0];

	// sequencer and result register
	logic              res_valid_q, r_side_q;
	logic [STAT_W-1:0] r_stat_q;
	logic [CELL_W-1:0] r_row_q, r_col_q;
	logic [KIND_W-1:0] r_kind_q;
	logic [DIST_W-1:0] r_dist_q;
	logic [LINE_W-1:0] r_top_q, r_bot_q;

	wire res_free = !res_valid_q || res.ready;
	wire is_hit   = (stat_q == ST_HIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_run_q   <= 1'b0;
			stat_q      <= ST_MISS;
			res_valid_q <= 1'b0;
			r_stat_q    <= '0;
			r_side_q    <= 1'b0;
			r_row_q     <= '0;
			r_col_q     <= '0;
			r_kind_q    <= '0;
			r_dist_q    <= '0;
			r_top_q     <= '0;
			r_bot_q     <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (div_start) begin
				div_run_q <= 1'b1;
			end else if (div_st.done) begin
				div_run_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (cmd_acc) begin
					state_q <= (cmd.opcode == OP_CAST) ? S_CAM : S_WR;
				end
				S_WR: begin
					stat_q  <= ST_WRITE;
					state_q <= S_FIN;
				end
				S_CAM:  if (div_st.done) state_q <= S_MULX;
				S_MULX: state_q <= S_RAYX;
				S_RAYX: state_q <= S_RAYY;
				S_RAYY: state_q <= S_DX;
				S_DX:   if (rx_zero || div_st.done) state_q <= S_DY;
				S_DY:   if (ry_zero || div_st.done) state_q <= S_SX;
				S_SX:   state_q <= S_SXW;
				S_SXW:  state_q <= S_SYW;
				S_SYW:  state_q <= S_STEP;
				S_STEP: begin
					if (limit_hit) begin
						stat_q  <= ST_MISS;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (out_of_map) begin
						stat_q  <= ST_MISS;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cell_hit) begin
						stat_q  <= ST_HIT;
						state_q <= S_LH;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_LH: if (dist_zero || div_st.done) state_q <= S_FIN;
				S_FIN: if (res_free) begin
					res_valid_q <= 1'b1;
					r_stat_q    <= stat_q;
					r_side_q    <= is_hit && side_q;
					r_row_q     <= is_hit ? mx_q[CELL_W-1:0] : '0;
					r_col_q     <= is_hit ? my_q[CELL_W-1:0] : '0;
					r_kind_q    <= is_hit ? kind_q : '0;
					r_dist_q    <= is_hit ? dist_q : '0;
					r_top_q     <= is_hit ? top_v : '0;
					r_bot_q     <= is_hit ? bot_v : '0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = r_stat_q;
	assign res.hit_side      = r_side_q;
	assign res.hit_row       = r_row_q;
	assign res.hit_col       = r_col_q;
	assign res.hit_kind      = r_kind_q;
	assign res.wall_distance = r_dist_q;
	assign res.line_top      = r_top_q;
	assign res.line_bottom   = r_bot_q;

`ifndef ASSERT_OFF
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !clr_busy_q)
		else $error("item taken while the map is being cleared");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CHK) |-> step_cnt_q <= SC_W'(STEP_LIMIT))
		else $error("dda step count past the limit");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> state_q != S_IDLE)
		else $error("accepted item not started");
`endif

endmodule
